[src/wavg_pkg.sv]
package wavg_pkg;

	localparam int WINDOW_DEF  = 5;
	localparam int SPEED_SCALE = 1000;
	localparam int SCALE_W     = 10;
	localparam int SPEED_W     = 28;
	localparam int DIST_W      = 16;
	localparam int TIME_W      = 32;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [TIME_W-1:0] timestamp;
		logic              restart;
	} sample_t;

	typedef struct packed {
		logic [SPEED_W-1:0] average_speed;
		logic [2:0]         samples_held;
		logic               full_res;
	} result_t;

endpackage

[src/wavg_div.sv]
module wavg_div #(
	parameter int DIV_W = 28
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIV_W-1:0]            dividend,
	input  logic [wavg_pkg::TIME_W-1:0] divisor,
	output logic                        done,
	output logic [DIV_W-1:0]            quotient
);
	import wavg_pkg::*;

	localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [TIME_W:0]   trial;
	logic [TIME_W:0]   diff;
	logic              fits;

	// One quotient bit per cycle, restoring form; the dividend shifts out
	// of the top of quo_q while quotient bits shift in at the bottom.
	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[src/window_average_speed_unit.sv]
// Sliding-window average speed of a distance sensor.
//
// Input channel (sample_valid/sample_ready, payload sample): one item holds a
// distance in hundredths of a centimeter, a millisecond timestamp and a
// restart flag. Restart empties the window before the item is stored.
// Output channel (result_valid/result_ready, payload result): exactly one
// item per input item, in order, with the average speed over the held
// samples, the number of samples held and a flag that the ring has filled.
//
// The edge that accepts an item also stores it. The sequencer then walks the
// ring through its single read port, loads the sum times 1000 into the
// serial divider and divides one quotient bit per cycle (29 bits at the
// default WINDOW of 5). A new item is taken only once the sequencer has
// passed the last result on to the output register.
// With fewer than two samples or a zero time span the divide is skipped.
// sample_ready is high only while the sequencer is idle. A finished item sits
// in the output register; the next input item is taken even while it waits,
// and the sequencer only holds its result back while result_ready stays low.
// Reset empties the window and drops any item in flight; the sample memory
// itself is not cleared, as a slot is read only after it has been written.
module window_average_speed_unit #(
	parameter int WINDOW = wavg_pkg::WINDOW_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  wavg_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output wavg_pkg::result_t result
);
	import wavg_pkg::*;

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = DIST_W + $clog2(WINDOW);
	localparam int DIV_W  = SUM_W + SCALE_W;
	localparam int EXT_W  = (DIV_W > SPEED_W) ? DIV_W : SPEED_W + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_LOAD = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic              filled_q;
	logic [CNT_W-1:0]  held_q;
	logic [SLOT_W-1:0] rd_addr_q;
	logic [CNT_W-1:0]  rd_left_q;
	logic              rd_vld_q;
	logic              first_q;
	logic              result_valid_q;

	logic [DIST_W-1:0] dist_mem [WINDOW];
	logic [TIME_W-1:0] time_mem [WINDOW];
	logic [DIST_W-1:0] dist_rd_q;
	logic [TIME_W-1:0] time_rd_q;

	logic [SUM_W-1:0]   sum_q;
	logic [DIST_W-1:0]  prev_q;
	logic [TIME_W-1:0]  ts_new_q;
	logic [TIME_W-1:0]  span_q;
	logic [SPEED_W-1:0] speed_q;
	result_t            result_q;

	// Slot bookkeeping for an incoming item.
	logic              accept;
	logic [SLOT_W-1:0] ws_base;
	logic              fl_base;
	logic              wrap;
	logic [SLOT_W-1:0] ws_next;
	logic              fl_next;
	logic [CNT_W-1:0]  held_next;
	logic [SLOT_W-1:0] oldest;
	logic [SLOT_W-1:0] rd_addr_next;
	logic [DIST_W-1:0] abs_diff;
	logic              walk_done;
	logic              load_out;

	logic              div_start;
	logic              div_done;
	logic [DIV_W-1:0]  div_dividend;
	logic [DIV_W-1:0]  div_quotient;
	logic [EXT_W-1:0]  quo_ext;
	logic [SPEED_W-1:0] speed_sat;

	assign accept    = sample_valid && sample_ready;
	assign ws_base   = sample.restart ? '0 : write_slot_q;
	assign fl_base   = sample.restart ? 1'b0 : filled_q;
	assign wrap      = (ws_base == SLOT_W'(WINDOW - 1));
	assign ws_next   = wrap ? '0 : ws_base + 1'b1;
	assign fl_next   = fl_base | wrap;
	assign held_next = fl_next ? CNT_W'(WINDOW) : CNT_W'(ws_next);
	// Oldest sample sits at the next write slot once the ring has wrapped.
	assign oldest    = fl_next ? ws_next : '0;

	assign rd_addr_next = (rd_addr_q == SLOT_W'(WINDOW - 1)) ? '0 : rd_addr_q + 1'b1;
	assign abs_diff     = (dist_rd_q >= prev_q) ? dist_rd_q - prev_q : prev_q - dist_rd_q;
	assign walk_done    = (rd_left_q == '0) && !rd_vld_q;
	assign load_out     = (state_q == S_OUT) && (!result_valid_q || result_ready);

	// The scaled sum goes straight into the divider's shift register.
	assign div_start    = (state_q == S_LOAD);
	assign div_dividend = DIV_W'(sum_q) * DIV_W'(SPEED_SCALE);

	assign quo_ext   = EXT_W'(div_quotient);
	assign speed_sat = (quo_ext[EXT_W-1:SPEED_W] != '0) ? '1 : quo_ext[SPEED_W-1:0];

	wavg_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// Sample ring: written when an item is taken, read one slot per cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			dist_mem[ws_base] <= sample.distance;
			time_mem[ws_base] <= sample.timestamp;
		end
		dist_rd_q <= dist_mem[rd_addr_q];
		time_rd_q <= time_mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			write_slot_q   <= '0;
			filled_q       <= 1'b0;
			held_q         <= '0;
			rd_addr_q      <= '0;
			rd_left_q      <= '0;
			rd_vld_q       <= 1'b0;
			first_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_vld_q <= 1'b0;
			if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						write_slot_q <= ws_next;
						filled_q     <= fl_next;
						held_q       <= held_next;
						rd_addr_q    <= oldest;
						rd_left_q    <= held_next;
						first_q      <= 1'b1;
						state_q      <= (held_next < CNT_W'(2)) ? S_OUT : S_WALK;
					end
				end
				S_WALK: begin
					if (rd_left_q != '0) begin
						rd_addr_q <= rd_addr_next;
						rd_left_q <= rd_left_q - 1'b1;
						rd_vld_q  <= 1'b1;
					end
					if (rd_vld_q) begin
						first_q <= 1'b0;
					end
					if (walk_done) begin
						state_q <= (span_q == '0) ? S_OUT : S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q    <= '0;
			ts_new_q <= sample.timestamp;
			speed_q  <= '0;
			span_q   <= '0;
		end
		if (state_q == S_WALK && rd_vld_q) begin
			prev_q <= dist_rd_q;
			if (first_q) begin
				span_q <= ts_new_q - time_rd_q;
			end else begin
				sum_q <= sum_q + SUM_W'(abs_diff);
			end
		end
		if (state_q == S_DIV && div_done) begin
			speed_q <= speed_sat;
		end
		if (load_out) begin
			result_q.average_speed <= speed_q;
			result_q.samples_held  <= 3'(held_q);
			result_q.full_res      <= filled_q;
		end
	end

	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[src/wavg_chk.sv]
module wavg_chk #(
	parameter int WINDOW = wavg_pkg::WINDOW_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_ready,
	input wavg_pkg::sample_t sample,
	input logic              result_valid,
	input logic              result_ready,
	input wavg_pkg::result_t result
);
	import wavg_pkg::*;

	// A held result does not change until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("second item taken while busy");

	// A filled window always holds the full window of samples.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.full_res |-> result.samples_held == 3'(WINDOW))
		else $error("full window with wrong sample count");

	// With fewer than two samples there is no speed.
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (WINDOW < 8) && (result.samples_held < 3'd2)
		|-> result.average_speed == '0)
		else $error("speed reported from fewer than two samples");

	// Until the ring fills the count stays below the window size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (WINDOW < 8) && !result.full_res
		|-> result.samples_held < 3'(WINDOW))
		else $error("sample count out of range");

endmodule

bind window_average_speed_unit wavg_chk #(.WINDOW(WINDOW)) u_wavg_chk (.*);
